@@ hw/rtl/sle_pkg.sv @@
// Shared types and fixed field widths for the segment loss estimator.
// No dependencies; every other file in hw/rtl imports this package.
package sle_pkg;

   localparam int SENT_W = 16;
   localparam int LOST_W = 16;
   localparam int TIME_W = 32;
   localparam int VAL_W  = 17;

   // Divider status seen by the top-level sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

@@ hw/rtl/sle_req_if.sv @@
// Request channel of the segment loss estimator: valid/ready plus one interval item.
// Depends on sle_pkg for the field widths.
interface sle_req_if import sle_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [SENT_W-1:0] sent_count;
   logic [LOST_W-1:0] lost_count;
   logic [TIME_W-1:0] time_stamp;

   modport source (output valid, output sent_count, output lost_count,
                   output time_stamp, input ready);
   modport sink   (input valid, input sent_count, input lost_count,
                   input time_stamp, output ready);
endinterface

@@ hw/rtl/sle_rsp_if.sv @@
// Response channel of the segment loss estimator: valid/ready plus one result item.
// Depends on sle_pkg for the field widths.
interface sle_rsp_if import sle_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [VAL_W-1:0]  loss_estimate;
   logic [VAL_W-1:0]  loss_variance;
   logic [TIME_W-1:0] loss_epoch;
   logic              rejected;

   modport source (output valid, output loss_estimate, output loss_variance,
                   output loss_epoch, output rejected, input ready);
   modport sink   (input valid, input loss_estimate, input loss_variance,
                   input loss_epoch, input rejected, output ready);
endinterface

@@ hw/rtl/segment_loss_estimator_top.sv @@
// Segment loss estimator: smoothed loss ratio and mean deviation, one result per item.
// Depends on sle_pkg, sle_req_if, sle_rsp_if and sle_divider.
//
// Each request item closes one measuring interval and yields exactly one response item
// carrying the state after the update. The loss ratio lost*LOSS_SCALE/sent comes from a
// bit-serial divider that retires one quotient bit per cycle. An item with lost >= sent
// skips the divider; an item with a zero sent count is rejected and leaves the state
// alone. One item is in flight at a time; a finished response waits in its output
// register without blocking the next request, and the sequencer only stalls at its last
// step if that register is still full.
module segment_loss_estimator_top import sle_pkg::*; #(
   parameter int LOSS_SCALE = 65536,
   parameter int COUNT_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   sle_req_if.sink      req_ch,
   sle_rsp_if.source    rsp_ch
);

   localparam int SB = $clog2(LOSS_SCALE + 1);
   localparam int PW = COUNT_BITS + SB;
   localparam logic [VAL_W-1:0] SCALE_V = VAL_W'(LOSS_SCALE);
   localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_LOSS,
      ST_VAR,
      ST_HOLD
   } state_type;

   state_type         state_ff, state_in;
   logic [VAL_W-1:0]  loss_ff, loss_in;
   logic [VAL_W-1:0]  var_ff, var_in;
   logic [TIME_W-1:0] epoch_ff, epoch_in;
   logic [VAL_W-1:0]  ratio_ff, ratio_in;
   logic [TIME_W-1:0] time_ff, time_in;
   logic              rej_ff, rej_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0]  rsp_loss_ff, rsp_loss_in;
   logic [VAL_W-1:0]  rsp_var_ff, rsp_var_in;
   logic [TIME_W-1:0] rsp_epoch_ff, rsp_epoch_in;
   logic              rsp_rej_ff, rsp_rej_in;

   logic [COUNT_BITS-1:0] sent_m;
   logic [COUNT_BITS-1:0] lost_m;
   logic                  accept;
   logic                  div_start;
   logic [PW-1:0]         product;
   logic [PW-1:0]         quotient;
   div_status_type        div_status;

   logic [VAL_W-1:0]      step;
   logic [VAL_W-1:0]      gap;
   logic [VAL_W:0]        var_sum;

   assign sent_m  = req_ch.sent_count[COUNT_BITS-1:0];
   assign lost_m  = req_ch.lost_count[COUNT_BITS-1:0];
   assign accept  = req_ch.valid && req_ch.ready;
   assign product = PW'(lost_m) * PW'(LOSS_SCALE);
   // Ratios at or above one saturate without a division.
   assign div_start = accept && (sent_m != '0) && (lost_m < sent_m);

   sle_divider #(
      .DW(PW),
      .VW(COUNT_BITS)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(product),
      .divisor (sent_m),
      .quotient(quotient),
      .status  (div_status)
   );

   always_comb begin
      state_in     = state_ff;
      loss_in      = loss_ff;
      var_in       = var_ff;
      epoch_in     = epoch_ff;
      ratio_in     = ratio_ff;
      time_in      = time_ff;
      rej_in       = rej_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_loss_in  = rsp_loss_ff;
      rsp_var_in   = rsp_var_ff;
      rsp_epoch_in = rsp_epoch_ff;
      rsp_rej_in   = rsp_rej_ff;
      step         = '0;
      gap          = '0;
      var_sum      = '0;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               time_in  = req_ch.time_stamp;
               ratio_in = SCALE_V;
               rej_in   = (sent_m == '0);
               if (sent_m == '0) begin
                  state_in = ST_HOLD;
               end else if (lost_m >= sent_m) begin
                  state_in = ST_LOSS;
               end else begin
                  state_in = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            if (div_status.done) begin
               ratio_in = quotient[VAL_W-1:0];
               state_in = ST_LOSS;
            end
         end
         ST_LOSS: begin
            // Move one eighth of the way toward the ratio; decay the variance by a quarter.
            if (ratio_ff >= loss_ff) begin
               step    = (ratio_ff - loss_ff) >> 3;
               loss_in = loss_ff + step;
            end else begin
               step    = (loss_ff - ratio_ff) >> 3;
               loss_in = loss_ff - step;
            end
            var_in   = var_ff - (var_ff >> 2);
            state_in = ST_VAR;
         end
         ST_VAR: begin
            gap      = (ratio_ff >= loss_ff) ? (ratio_ff - loss_ff) : (loss_ff - ratio_ff);
            var_sum  = {1'b0, var_ff} + {1'b0, gap >> 2};
            var_in   = var_sum[VAL_W] ? VAL_MAX : var_sum[VAL_W-1:0];
            epoch_in = time_ff;
            state_in = ST_HOLD;
         end
         ST_HOLD: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_loss_in  = loss_ff;
               rsp_var_in   = var_ff;
               rsp_epoch_in = epoch_ff;
               rsp_rej_in   = rej_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         loss_ff      <= '0;
         var_ff       <= '0;
         epoch_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         loss_ff      <= loss_in;
         var_ff       <= var_in;
         epoch_ff     <= epoch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ratio_ff     <= ratio_in;
      time_ff      <= time_in;
      rej_ff       <= rej_in;
      rsp_loss_ff  <= rsp_loss_in;
      rsp_var_ff   <= rsp_var_in;
      rsp_epoch_ff <= rsp_epoch_in;
      rsp_rej_ff   <= rsp_rej_in;
   end

   assign req_ch.ready         = (state_ff == ST_IDLE) && !div_status.busy;
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.loss_estimate = rsp_loss_ff;
   assign rsp_ch.loss_variance = rsp_var_ff;
   assign rsp_ch.loss_epoch    = rsp_epoch_ff;
   assign rsp_ch.rejected      = rsp_rej_ff;

endmodule

@@ hw/rtl/sle_divider.sv @@
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
// Depends on sle_pkg for the status struct.
module sle_divider import sle_pkg::*; #(
   parameter int DW = 33,
   parameter int VW = 16
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [DW-1:0]  dividend,
   input  logic [VW-1:0]  divisor,
   output logic [DW-1:0]  quotient,
   output div_status_type status
);

   localparam int CW = $clog2(DW + 1);

   logic [DW-1:0] num_ff, num_in;
   logic [VW-1:0] rem_ff, rem_in;
   logic [VW-1:0] den_ff, den_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          done_ff, done_in;

   logic [VW:0]   trial;
   logic [VW:0]   diff;
   logic          qbit;

   // The dividend shifts out at the top while quotient bits shift in at the bottom.
   always_comb begin
      trial   = {rem_ff, num_ff[DW-1]};
      diff    = trial - {1'b0, den_ff};
      qbit    = (trial >= {1'b0, den_ff});
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         num_in = dividend;
         rem_in = '0;
         den_in = divisor;
         cnt_in = CW'(DW);
      end else if (cnt_ff != '0) begin
         num_in  = {num_ff[DW-2:0], qbit};
         rem_in  = qbit ? diff[VW-1:0] : trial[VW-1:0];
         cnt_in  = cnt_ff - CW'(1);
         done_in = (cnt_ff == CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign quotient    = num_ff;
   assign status.busy = (cnt_ff != '0);
   assign status.done = done_ff;

endmodule

@@ hw/rtl/sle_checker.sv @@
// Port-level checks for the segment loss estimator, bound to the top level.
// Depends on sle_pkg for the field widths and on segment_loss_estimator_top.
module sle_checker import sle_pkg::*; #(
   parameter int LOSS_SCALE = 65536
) (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [VAL_W-1:0]  rsp_loss_estimate,
   input logic [VAL_W-1:0]  rsp_loss_variance,
   input logic [TIME_W-1:0] rsp_loss_epoch,
   input logic              rsp_rejected
);

   localparam logic [VAL_W-1:0] SCALE_V = VAL_W'(LOSS_SCALE);

   // Reset leaves no item on the response side.
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Only one item is worked on at a time.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while an item was in flight");

   // Ratios never exceed the scale, so neither do their smoothed forms.
   a_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_loss_estimate <= SCALE_V) && (rsp_loss_variance <= SCALE_V))
      else $error("estimate or variance above the loss scale");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_loss_estimate)
         && $stable(rsp_loss_variance) && $stable(rsp_loss_epoch)
         && $stable(rsp_rejected))
      else $error("stalled response item changed");

endmodule

bind segment_loss_estimator_top sle_checker #(
   .LOSS_SCALE(LOSS_SCALE)
) u_sle_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_loss_estimate(rsp_ch.loss_estimate),
   .rsp_loss_variance(rsp_ch.loss_variance),
   .rsp_loss_epoch   (rsp_ch.loss_epoch),
   .rsp_rejected     (rsp_ch.rejected)
);

@@ tb/sv/tb.sv @@
// Self-checking testbench for segment_loss_estimator_top: drives interval items, predicts
// the smoothed loss, variance and epoch per item, and compares every response field.
// Depends on sle_pkg, sle_req_if, sle_rsp_if and the estimator RTL.
module tb import sle_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LOSS_SCALE   = 65536;
   localparam int COUNT_BITS   = 16;
   localparam int VAL17_MAX    = 131071;
   localparam int PHASE_ITEMS  = 250;
   localparam int HOLD_CYCLES  = 300;
   localparam int SETTLE_CYCLES = 60;
   localparam int CYCLE_LIMIT  = 900000;

   typedef enum int {
      PH_FREE,
      PH_SENDER_IDLE,
      PH_RECEIVER_STALL,
      PH_BOTH
   } idle_phase_type;

   typedef struct {
      logic [SENT_W-1:0] sent;
      logic [LOST_W-1:0] lost;
      logic [TIME_W-1:0] stime;
      idle_phase_type    phase;
      bit                drain;
      bit                hold;
   } interval_item_type;

   typedef struct {
      logic [VAL_W-1:0]  loss_estimate;
      logic [VAL_W-1:0]  loss_variance;
      logic [TIME_W-1:0] loss_epoch;
      logic              rejected;
   } loss_result_type;

   logic clock;
   logic reset;

   sle_req_if req_if();
   sle_rsp_if rsp_if();

   segment_loss_estimator_top #(
      .LOSS_SCALE(LOSS_SCALE),
      .COUNT_BITS(COUNT_BITS)
   ) u_top (
      .clock (clock),
      .reset (reset),
      .req_ch(req_if),
      .rsp_ch(rsp_if)
   );

   interval_item_type pend_q[$];
   loss_result_type   expected_q[$];
   interval_item_type cur_item;
   idle_phase_type    cur_phase;

   // Predicted estimator state.
   logic [31:0] est_loss;
   logic [31:0] est_var;
   logic [31:0] est_epoch;

   int    n_req_sent;
   int    n_rsp_seen;
   int    n_total;
   int    n_rejected;
   int    n_saturated;
   int    err_count;
   int    cycles;
   int    hold_left;
   logic  hold_start;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   task automatic report_mismatch(string msg);
      $display("MISMATCH: %s", msg);
      err_count++;
   endtask

   function automatic loss_result_type update_loss_state(interval_item_type it);
      loss_result_type r;
      logic [31:0]  sent;
      logic [31:0]  lost;
      logic [31:0]  ratio;
      logic [31:0]  var_n;
      logic [31:0]  gap;
      logic [63:0]  quot;
      sent = 32'(it.sent) & ((32'd1 << COUNT_BITS) - 32'd1);
      lost = 32'(it.lost) & ((32'd1 << COUNT_BITS) - 32'd1);
      r.rejected = 1'b0;
      if (sent == 0) begin
         r.rejected = 1'b1;
         n_rejected++;
      end else begin
         if (lost >= sent) begin
            ratio = LOSS_SCALE;
            n_saturated++;
         end else begin
            quot = (64'(lost) * 64'(LOSS_SCALE)) / 64'(sent);
            if (quot > 64'(LOSS_SCALE)) quot = 64'(LOSS_SCALE);
            ratio = quot[31:0];
         end
         var_n = est_var - est_var / 4;
         // The gap is taken against the estimate after its step.
         if (ratio >= est_loss) begin
            est_loss = est_loss + (ratio - est_loss) / 8;
            gap = ratio - est_loss;
         end else begin
            est_loss = est_loss - (est_loss - ratio) / 8;
            gap = est_loss - ratio;
         end
         var_n = var_n + gap / 4;
         if (var_n > VAL17_MAX) var_n = VAL17_MAX;
         est_loss  = est_loss & VAL17_MAX;
         est_var   = var_n;
         est_epoch = it.stime;
      end
      r.loss_estimate = est_loss[VAL_W-1:0];
      r.loss_variance = est_var[VAL_W-1:0];
      r.loss_epoch    = est_epoch;
      return r;
   endfunction

   function automatic interval_item_type make_interval(logic [31:0] sent, logic [31:0] lost,
                                                       logic [31:0] stime,
                                                       idle_phase_type phase);
      interval_item_type it;
      it.sent  = sent[SENT_W-1:0];
      it.lost  = lost[LOST_W-1:0];
      it.stime = stime;
      it.phase = phase;
      it.drain = 1'b0;
      it.hold  = 1'b0;
      return it;
   endfunction

   function automatic interval_item_type random_interval(idle_phase_type phase);
      int kind;
      int s;
      int l;
      kind = $urandom_range(99);
      if (kind < 6) begin
         s = 0;
         l = $urandom_range(65535);
      end else if (kind < 16) begin
         s = $urandom_range(65535, 1);
         l = $urandom_range(65535, s);
      end else begin
         // Small sent counts, on about a third of these items, keep ratios coarse and moving.
         if (kind < 45) s = $urandom_range(255, 1);
         else s = $urandom_range(65535, 1);
         if (kind < 70) l = $urandom_range(s / 16, 0);
         else l = $urandom_range(s - 1, 0);
      end
      return make_interval(s, l, $urandom, phase);
   endfunction

   function automatic int sender_idle_pct(idle_phase_type ph);
      case (ph)
         PH_SENDER_IDLE: return 74;
         PH_BOTH:        return 22;
         default:        return 0;
      endcase
   endfunction

   function automatic int receiver_stall_pct(idle_phase_type ph);
      case (ph)
         PH_RECEIVER_STALL: return 74;
         PH_BOTH:           return 22;
         default:           return 0;
      endcase
   endfunction

   // Request driver: holds each item until it is taken, then pulls the next one.
   always @(posedge clock) begin
      interval_item_type nxt;
      bit                offer;
      bit                start_hold;
      if (reset) begin
         req_if.valid <= 1'b0;
         hold_start   <= 1'b0;
      end else begin
         offer      = req_if.valid;
         start_hold = 1'b0;
         if (req_if.valid && req_if.ready) begin
            expected_q.push_back(update_loss_state(cur_item));
            n_req_sent++;
            offer = 1'b0;
         end
         if (!offer && pend_q.size() != 0) begin
            nxt = pend_q[0];
            if (nxt.drain && n_rsp_seen != n_req_sent) begin
               offer = 1'b0;
            end else if ($urandom_range(99) < sender_idle_pct(nxt.phase)) begin
               offer = 1'b0;
            end else begin
               void'(pend_q.pop_front());
               cur_item   = nxt;
               offer      = 1'b1;
               start_hold = nxt.hold;
               cur_phase  <= nxt.phase;
            end
         end
         req_if.valid <= offer;
         if (offer) begin
            req_if.sent_count <= cur_item.sent;
            req_if.lost_count <= cur_item.lost;
            req_if.time_stamp <= cur_item.stime;
         end
         hold_start <= start_hold;
      end
   end

   // Long receiver hold-off, counted on its own.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_start) begin
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Response monitor: checks each result against the oldest prediction.
   always @(posedge clock) begin
      loss_result_type want;
      bit              rdy;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_q.size() == 0) begin
               report_mismatch("result arrived with no item outstanding");
            end else begin
               want = expected_q.pop_front();
               if (rsp_if.loss_estimate !== want.loss_estimate)
                  report_mismatch($sformatf("result %0d loss_estimate got %0d want %0d",
                                  n_rsp_seen, rsp_if.loss_estimate, want.loss_estimate));
               if (rsp_if.loss_variance !== want.loss_variance)
                  report_mismatch($sformatf("result %0d loss_variance got %0d want %0d",
                                  n_rsp_seen, rsp_if.loss_variance, want.loss_variance));
               if (rsp_if.loss_epoch !== want.loss_epoch)
                  report_mismatch($sformatf("result %0d loss_epoch got %h want %h",
                                  n_rsp_seen, rsp_if.loss_epoch, want.loss_epoch));
               if (rsp_if.rejected !== want.rejected)
                  report_mismatch($sformatf("result %0d rejected got %b want %b",
                                  n_rsp_seen, rsp_if.rejected, want.rejected));
            end
            n_rsp_seen <= n_rsp_seen + 1;
         end
         rdy = (hold_left == 0) && ($urandom_range(99) >= receiver_stall_pct(cur_phase));
         rsp_if.ready <= rdy;
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d of %0d results seen",
                  cycles, n_rsp_seen, n_total);
         $display("[segment_loss_estimator_top] ERROR");
         $finish;
      end
   end

   initial begin
      interval_item_type it;
      idle_phase_type    phase_seq[5];
      reset             = 1'b1;
      req_if.valid      = 1'b0;
      req_if.sent_count = '0;
      req_if.lost_count = '0;
      req_if.time_stamp = '0;
      rsp_if.ready      = 1'b0;
      hold_start        = 1'b0;
      hold_left         = 0;
      cur_phase         = PH_FREE;
      cycles            = 0;
      n_req_sent        = 0;
      n_rsp_seen        = 0;
      n_rejected        = 0;
      n_saturated       = 0;
      err_count         = 0;
      est_loss          = '0;
      est_var           = '0;
      est_epoch         = '0;

      // Directed items: rejection on the reset state, saturation, extremes of every field.
      pend_q.push_back(make_interval(0, 0, 0, PH_FREE));
      pend_q.push_back(make_interval(0, 32'h0000ffff, 32'hffffffff, PH_FREE));
      pend_q.push_back(make_interval(1, 0, 1, PH_FREE));
      pend_q.push_back(make_interval(32'h0000ffff, 32'h0000ffff, 32'hffffffff, PH_FREE));
      pend_q.push_back(make_interval(1, 32'h0000ffff, 32'h00000002, PH_FREE));
      for (int i = 0; i < 6; i++)
         pend_q.push_back(make_interval(1, 1, 32'h100 + i, PH_FREE));
      pend_q.push_back(make_interval(32'h0000ffff, 32'h0000fffe, 32'h12345678, PH_FREE));
      pend_q.push_back(make_interval(32'h0000ffff, 1, 32'h80000000, PH_FREE));
      pend_q.push_back(make_interval(32'h00008000, 32'h00004000, 32'h7fffffff, PH_FREE));
      pend_q.push_back(make_interval(3, 1, 32'h00000003, PH_FREE));
      pend_q.push_back(make_interval(0, 1, 32'hdeadbeef, PH_FREE));
      for (int i = 0; i < 4; i++)
         pend_q.push_back(make_interval(32'h0000ffff, 0, 32'h200 + i, PH_FREE));
      pend_q.push_back(make_interval(2, 1, 32'h0000ffff, PH_FREE));
      pend_q.push_back(make_interval(32'h0000aaaa, 32'h00005555, 32'haaaaaaaa, PH_FREE));
      pend_q.push_back(make_interval(32'h00005555, 32'h00002aaa, 32'h55555555, PH_FREE));
      pend_q.push_back(make_interval(32'h00000100, 32'h000000ff, 32'h00000000, PH_FREE));

      phase_seq = '{PH_FREE, PH_SENDER_IDLE, PH_RECEIVER_STALL, PH_BOTH, PH_FREE};
      for (int p = 0; p < 5; p++) begin
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            it = random_interval(phase_seq[p]);
            // Each phase starts only after everything before it has come back.
            if (i == 0) it.drain = 1'b1;
            // Early in the free-running phase the receiver holds off for a long while.
            if (p == 0 && i == 40) it.hold = 1'b1;
            pend_q.push_back(it);
         end
      end
      n_total = pend_q.size();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (!(n_req_sent == n_total && n_rsp_seen == n_total)) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_q.size() != 0)
         report_mismatch($sformatf("%0d expected results never arrived", expected_q.size()));

      $display("covered %0d interval items (%0d rejected, %0d saturated) in %0d cycles,",
               n_total, n_rejected, n_saturated, cycles);
      $display("across free, sender-idle, receiver-stall and mixed phases; %0d mismatches",
               err_count);
      if (err_count == 0) begin
         $display("[segment_loss_estimator_top] OK");
      end else begin
         $display("[segment_loss_estimator_top] ERROR");
      end
      $finish;
   end

endmodule

@@ segment_loss_estimator_top.f @@
hw/rtl/sle_pkg.sv
hw/rtl/sle_req_if.sv
hw/rtl/sle_rsp_if.sv
hw/rtl/sle_divider.sv
hw/rtl/segment_loss_estimator_top.sv
hw/rtl/sle_checker.sv
tb/sv/tb.sv
